### src/askt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askt_pkg: shared types for the aging session key table
// Operation codes, the entry record handed between neighbor cells and the
// control bundle that the sequencer broadcasts to every cell.
// ----------------------------------------------------------------------------
package askt_pkg;

	localparam int KEY_HIGH_W = 16;
	localparam int KEY_LOW_W  = 64;
	localparam int EXPIRY_W   = 32;
	localparam int TIMEOUT_W  = 16;
	localparam int COUNT_W    = 4;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1800;

	typedef enum logic [1:0] {
		OP_CREATE   = 2'd0,
		OP_VALIDATE = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	// One table entry as it moves from cell to cell
	typedef struct packed {
		logic                  valid;
		logic                  dead;
		logic [KEY_HIGH_W-1:0] key_high;
		logic [KEY_LOW_W-1:0]  key_low;
		logic [EXPIRY_W-1:0]   expiry;
	} entry_t;

	// Broadcast control from the sequencer to the cells
	typedef struct packed {
		logic                  eval;
		logic                  mark;
		logic                  compact;
		logic                  append;
		logic                  full;
		op_t                   op;
		logic [KEY_HIGH_W-1:0] key_high;
		logic [KEY_LOW_W-1:0]  key_low;
		logic [EXPIRY_W-1:0]   now;
		logic [EXPIRY_W-1:0]   new_exp;
	} cell_ctl_t;

endpackage

### src/askt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askt_cell: one slot of the session table
// Holds one entry, compares it against the current transaction, marks it for
// removal and shifts toward the oldest end on a mark at or below or a full append.
// ----------------------------------------------------------------------------
module askt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  askt_pkg::cell_ctl_t ctl,
	input  logic                wr_sel,
	input  askt_pkg::entry_t    up_in,
	output askt_pkg::entry_t    ent_out,
	input  logic                prior_in,
	output logic                prior_out,
	input  logic                seen_in,
	output logic                seen_out
);

	logic                            valid_q;
	logic                            dead_q;
	logic [askt_pkg::KEY_HIGH_W-1:0] key_high_q;
	logic [askt_pkg::KEY_LOW_W-1:0]  key_low_q;
	logic [askt_pkg::EXPIRY_W-1:0]   expiry_q;
	logic                            expired_q;
	logic                            match_q;
	logic                            live_match;
	logic                            mark_dead;
	logic                            hit_here;
	logic                            take_up;
	logic                            take_new;

	// Resolve this slot's fate from the flags and the chain below
	always_comb begin
		live_match = valid_q & match_q & ~expired_q;
		mark_dead  = 1'b0;
		hit_here   = 1'b0;
		prior_out  = prior_in;
		unique case (ctl.op)
			askt_pkg::OP_CREATE: begin
				mark_dead = valid_q & expired_q;
			end
			askt_pkg::OP_VALIDATE: begin
				mark_dead = valid_q & expired_q & ~prior_in;
				hit_here  = live_match & ~prior_in;
				prior_out = prior_in | live_match;
			end
			askt_pkg::OP_REMOVE: begin
				mark_dead = valid_q & match_q & ~prior_in;
				prior_out = prior_in | (valid_q & match_q);
			end
			default: begin
				mark_dead = 1'b0;
			end
		endcase
	end

	// Shift when this slot or one below it is marked, or on append to a full row
	assign seen_out = seen_in | dead_q;
	assign take_up  = (ctl.compact & seen_out) | (ctl.append & ctl.full);
	assign take_new = ctl.append & ~ctl.full & wr_sel;

	assign ent_out.valid    = valid_q;
	assign ent_out.dead     = dead_q;
	assign ent_out.key_high = key_high_q;
	assign ent_out.key_low  = key_low_q;
	assign ent_out.expiry   = expiry_q;

	// Hold valid and removal marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dead_q  <= 1'b0;
		end else if (ctl.mark) begin
			dead_q <= mark_dead;
		end else if (take_up) begin
			valid_q <= up_in.valid;
			dead_q  <= up_in.dead;
		end else if (take_new) begin
			valid_q <= 1'b1;
			dead_q  <= 1'b0;
		end
	end

	// Compare, extend and move the payload
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			expired_q <= expiry_q < ctl.now;
			match_q   <= (key_high_q == ctl.key_high) && (key_low_q == ctl.key_low);
		end
		if (ctl.mark && hit_here) begin
			expiry_q <= ctl.new_exp;
		end else if (take_up) begin
			key_high_q <= up_in.key_high;
			key_low_q  <= up_in.key_low;
			expiry_q   <= up_in.expiry;
		end else if (take_new) begin
			key_high_q <= ctl.key_high;
			key_low_q  <= ctl.key_low;
			expiry_q   <= ctl.new_exp;
		end
	end

endmodule

### src/aging_session_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_session_key_table: ordered table of expiring 80-bit session keys
// A row of MAX_SESSIONS cells, oldest entry in cell 0, run by a sequencer that
// compares, marks, compacts and appends, one step per cycle; a stalled output holds it.
//
//   channel   signals                                         direction
//   in        in_valid/in_ready, operation, key_high,          into block
//             key_low, now_seconds
//   out       out_valid/out_ready, hit, evicted_oldest,         out of block
//             expired_dropped, live_count
//   cfg       cfg_valid/cfg_ready, cfg_data (session_timeout)   into block
//
// An item steps through evaluate, mark, compact, append (create only) and
// done to a registered result; compact repeats while a marked entry remains,
// since the cell row closes one gap per cycle. One item is in work at a time;
// in_ready is high only when the sequencer is idle. A result held on a stalled
// output does not block the next acceptance, only the delivery of that next
// result. Reset empties the table and loads a timeout of 1800 seconds.
// ----------------------------------------------------------------------------
module aging_session_key_table #(
	parameter int MAX_SESSIONS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] key_high,
	input  logic [63:0] key_low,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic        evicted_oldest,
	output logic [3:0]  expired_dropped,
	output logic [3:0]  live_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(MAX_SESSIONS + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SESSIONS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MARK,
		ST_COMPACT,
		ST_APPEND,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [askt_pkg::TIMEOUT_W-1:0]  timeout_q;
	askt_pkg::op_t                   op_q;
	logic [askt_pkg::KEY_HIGH_W-1:0] key_high_q;
	logic [askt_pkg::KEY_LOW_W-1:0]  key_low_q;
	logic [askt_pkg::EXPIRY_W-1:0]   now_q;
	logic [askt_pkg::EXPIRY_W-1:0]   new_exp_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   dropped_q;
	logic                            hit_q;
	logic                            evicted_q;
	logic                            out_valid_q;
	logic                            out_hit_q;
	logic                            out_evicted_q;
	logic [askt_pkg::COUNT_W-1:0]    out_dropped_q;
	logic [askt_pkg::COUNT_W-1:0]    out_count_q;

	askt_pkg::cell_ctl_t             ctl;
	askt_pkg::entry_t                ent [MAX_SESSIONS+1];
	logic [MAX_SESSIONS:0]           prior;
	logic [MAX_SESSIONS:0]           seen;
	logic [askt_pkg::EXPIRY_W:0]     exp_sum;
	logic                            full;
	logic                            out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign full      = (count_q == FULL_COUNT);
	assign out_free  = ~out_valid_q | out_ready;
	assign exp_sum   = {1'b0, now_q} + (askt_pkg::EXPIRY_W+1)'(timeout_q);

	// Broadcast control to the cell row
	always_comb begin
		ctl.eval     = (state_q == ST_EVAL);
		ctl.mark     = (state_q == ST_MARK);
		ctl.compact  = (state_q == ST_COMPACT);
		ctl.append   = (state_q == ST_APPEND);
		ctl.full     = full;
		ctl.op       = op_q;
		ctl.key_high = key_high_q;
		ctl.key_low  = key_low_q;
		ctl.now      = now_q;
		ctl.new_exp  = new_exp_q;
	end

	// Feed the newest end: the new key on append, an empty slot otherwise
	assign ent[MAX_SESSIONS].valid    = (state_q == ST_APPEND);
	assign ent[MAX_SESSIONS].dead     = 1'b0;
	assign ent[MAX_SESSIONS].key_high = key_high_q;
	assign ent[MAX_SESSIONS].key_low  = key_low_q;
	assign ent[MAX_SESSIONS].expiry   = new_exp_q;
	assign prior[0] = 1'b0;
	assign seen[0]  = 1'b0;

	for (genvar i = 0; i < MAX_SESSIONS; i++) begin : g_cell
		askt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wr_sel    (count_q == CW'(i)),
			.up_in     (ent[i+1]),
			.ent_out   (ent[i]),
			.prior_in  (prior[i]),
			.prior_out (prior[i+1]),
			.seen_in   (seen[i]),
			.seen_out  (seen[i+1])
		);
	end

	// Capture the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= askt_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	// Hold the transaction fields and the saturated expiry
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q       <= askt_pkg::op_t'(operation);
			key_high_q <= key_high;
			key_low_q  <= key_low;
			now_q      <= now_seconds;
		end
		if (state_q == ST_EVAL) begin
			new_exp_q <= exp_sum[askt_pkg::EXPIRY_W] ? '1 : exp_sum[askt_pkg::EXPIRY_W-1:0];
		end
	end

	// Sequence the steps of one transaction and register its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			dropped_q     <= '0;
			hit_q         <= 1'b0;
			evicted_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_hit_q     <= 1'b0;
			out_evicted_q <= 1'b0;
			out_dropped_q <= '0;
			out_count_q   <= '0;
		end else begin
			// Drop the delivered result unless a new one takes its place
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						dropped_q <= '0;
						hit_q     <= 1'b0;
						evicted_q <= 1'b0;
						state_q   <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_MARK;
				end
				ST_MARK: begin
					hit_q   <= prior[MAX_SESSIONS];
					state_q <= ST_COMPACT;
				end
				ST_COMPACT: begin
					if (seen[MAX_SESSIONS]) begin
						count_q <= count_q - 1'b1;
						if (op_q != askt_pkg::OP_REMOVE) begin
							dropped_q <= dropped_q + 1'b1;
						end
					end else if (op_q == askt_pkg::OP_CREATE) begin
						state_q <= ST_APPEND;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_APPEND: begin
					if (full) begin
						evicted_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_hit_q     <= hit_q;
						out_evicted_q <= evicted_q;
						out_dropped_q <= askt_pkg::COUNT_W'(dropped_q);
						out_count_q   <= askt_pkg::COUNT_W'(count_q);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = out_hit_q;
	assign evicted_oldest  = out_evicted_q;
	assign expired_dropped = out_dropped_q;
	assign live_count      = out_count_q;

endmodule

### tb/session_table_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_table_monitor: predicts and checks the aging session key table
// Watches the request, result and timeout channels of the block. It keeps its
// own copy of the ordered key table and the timeout. It predicts one result
// for each accepted request and compares each delivered result field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module session_table_monitor
	import askt_pkg::*;
#(
	parameter int MAX_SESSIONS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] key_high,
	input  logic [63:0] key_low,
	input  logic [31:0] now_seconds,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        hit,
	input  logic        evicted_oldest,
	input  logic [3:0]  expired_dropped,
	input  logic [3:0]  live_count,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic               hit;
		logic               evicted;
		logic [COUNT_W-1:0] dropped;
		logic [COUNT_W-1:0] live;
	} session_result_t;

	// Shadow table, oldest entry at index 0
	logic [KEY_HIGH_W-1:0] row_kh  [MAX_SESSIONS];
	logic [KEY_LOW_W-1:0]  row_kl  [MAX_SESSIONS];
	logic [EXPIRY_W-1:0]   row_exp [MAX_SESSIONS];
	int                    occupancy;
	logic [TIMEOUT_W-1:0]  lifetime;

	session_result_t predicted_outcomes [$];
	int              result_index;

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Grant a fresh lifetime, clamped at the top of the time range
	function automatic logic [EXPIRY_W-1:0] renewed_expiry(input logic [EXPIRY_W-1:0] now);
		logic [EXPIRY_W:0] sum;
		sum = {1'b0, now} + (EXPIRY_W+1)'(lifetime);
		return sum[EXPIRY_W] ? {EXPIRY_W{1'b1}} : sum[EXPIRY_W-1:0];
	endfunction

	// Drop one entry and shift the younger ones down
	task automatic close_gap(input int idx);
		int j;
		for (j = idx; j + 1 < occupancy; j++) begin
			row_kh[j]  = row_kh[j+1];
			row_kl[j]  = row_kl[j+1];
			row_exp[j] = row_exp[j+1];
		end
		occupancy--;
	endtask

	task automatic apply_session_op(
		input  op_t                   op,
		input  logic [KEY_HIGH_W-1:0] kh,
		input  logic [KEY_LOW_W-1:0]  kl,
		input  logic [EXPIRY_W-1:0]   now,
		output session_result_t       r
	);
		int i;
		r = '0;
		i = 0;
		case (op)
			OP_CREATE: begin
				// purge every expired entry, then make room and append
				while (i < occupancy) begin
					if (row_exp[i] < now) begin
						close_gap(i);
						r.dropped = r.dropped + 1'b1;
					end else begin
						i++;
					end
				end
				if (occupancy >= MAX_SESSIONS) begin
					close_gap(0);
					r.evicted = 1'b1;
				end
				row_kh[occupancy]  = kh;
				row_kl[occupancy]  = kl;
				row_exp[occupancy] = renewed_expiry(now);
				occupancy++;
			end
			OP_VALIDATE: begin
				// walk until the first live match; later entries stay untouched
				while (i < occupancy && !r.hit) begin
					if (row_exp[i] < now) begin
						close_gap(i);
						r.dropped = r.dropped + 1'b1;
					end else if (row_kh[i] == kh && row_kl[i] == kl) begin
						row_exp[i] = renewed_expiry(now);
						r.hit = 1'b1;
					end else begin
						i++;
					end
				end
			end
			OP_REMOVE: begin
				// delete the first match, live or not
				while (i < occupancy && !r.hit) begin
					if (row_kh[i] == kh && row_kl[i] == kl) begin
						close_gap(i);
						r.hit = 1'b1;
					end else begin
						i++;
					end
				end
			end
			default: ;
		endcase
		r.live = occupancy[COUNT_W-1:0];
	endtask

	// Track every transaction on the three channels
	always @(posedge clk or negedge arst_n) begin : track
		session_result_t want;
		if (!arst_n) begin
			occupancy    = 0;
			lifetime     = TIMEOUT_RESET;
			result_index = 0;
			mismatches   = 0;
			predicted_outcomes.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_outcomes.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with no request pending",
						result_index));
				end else begin
					want = predicted_outcomes.pop_front();
					if (hit !== want.hit)
						flag_mismatch($sformatf("result %0d hit: expected %0d, got %0d",
							result_index, want.hit, hit));
					if (evicted_oldest !== want.evicted)
						flag_mismatch($sformatf("result %0d evicted_oldest: expected %0d, got %0d",
							result_index, want.evicted, evicted_oldest));
					if (expired_dropped !== want.dropped)
						flag_mismatch($sformatf("result %0d expired_dropped: expected %0d, got %0d",
							result_index, want.dropped, expired_dropped));
					if (live_count !== want.live)
						flag_mismatch($sformatf("result %0d live_count: expected %0d, got %0d",
							result_index, want.live, live_count));
				end
				result_index++;
			end
			if (cfg_valid && cfg_ready)
				lifetime = cfg_data;
			if (in_valid && in_ready) begin
				apply_session_op(op_t'(operation), key_high, key_low, now_seconds, want);
				predicted_outcomes.push_back(want);
			end
		end
		outstanding = predicted_outcomes.size();
	end

endmodule

### tb/tb_aging_session_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aging_session_key_table: stimulus and verdict for the session key table
// Runs a directed pass over empty-table lookups, duplicates, overflow,
// mass expiry, expiry clamping and a zero lifetime. Then it runs random
// phases under several timeout settings, with a small pool of reused keys so
// that lookups hit. Both sides idle at random, and one long result stall
// backs the block up. The monitor beside the block does all checking.
// ----------------------------------------------------------------------------
module tb_aging_session_key_table;
	import askt_pkg::*;

	localparam int HALF_PERIOD      = 6;
	localparam int RESET_CYCLES     = 9;
	localparam int STALL_LIMIT      = 2000;
	localparam int LONG_HOLD        = 400;
	localparam int SETTLE_CYCLES    = 20;
	localparam int POOL_SIZE        = 12;
	localparam int RANDOM_PER_PHASE = 140;
	localparam int PHASES           = 6;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [15:0] key_high;
	logic [63:0] key_low;
	logic [31:0] now_seconds;
	logic        out_valid;
	logic        out_ready;
	logic        hit;
	logic        evicted_oldest;
	logic [3:0]  expired_dropped;
	logic [3:0]  live_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	int          mismatches;
	int          outstanding;
	int          quiet_cycles = 0;
	bit          calm;
	bit          hold_request;
	logic [15:0] timeout_now;
	logic [31:0] wall_clock;
	logic [15:0] pool_kh [POOL_SIZE];
	logic [63:0] pool_kl [POOL_SIZE];

	aging_session_key_table #(.MAX_SESSIONS(10)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.key_high        (key_high),
		.key_low         (key_low),
		.now_seconds     (now_seconds),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.evicted_oldest  (evicted_oldest),
		.expired_dropped (expired_dropped),
		.live_count      (live_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	session_table_monitor #(.MAX_SESSIONS(10)) monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.key_high        (key_high),
		.key_low         (key_low),
		.now_seconds     (now_seconds),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.evicted_oldest  (evicted_oldest),
		.expired_dropped (expired_dropped),
		.live_count      (live_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	always #HALF_PERIOD clk = ~clk;

	// Count cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Result side: one long hold on request, short random stalls otherwise
	initial begin : receiver
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 99) < 15) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Present one request and hold it until accepted, then maybe pause
	task automatic offer(input op_t op, input logic [15:0] kh, input logic [63:0] kl,
			input logic [31:0] now);
		in_valid    <= 1'b1;
		operation   <= op;
		key_high    <= kh;
		key_low     <= kl;
		now_seconds <= now;
		do @(posedge clk); while (!in_ready);
		if (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every result is delivered
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	task automatic load_timeout(input logic [15:0] value);
		cfg_valid   <= 1'b1;
		cfg_data    <= value;
		timeout_now = value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random request: mostly pool keys, time creeping forward with rare jumps
	task automatic offer_random();
		op_t         op;
		int          roll;
		int          slot;
		logic [15:0] kh;
		logic [63:0] kl;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			op = OP_CREATE;
		else if (roll < 75)
			op = OP_VALIDATE;
		else if (roll < 93)
			op = OP_REMOVE;
		else
			op = OP_NONE;
		if ($urandom_range(0, 99) < 15) begin
			slot = $urandom_range(0, POOL_SIZE - 1);
			pool_kh[slot] = 16'($urandom);
			pool_kl[slot] = {$urandom, $urandom};
		end
		slot = $urandom_range(0, POOL_SIZE - 1);
		kh = pool_kh[slot];
		kl = pool_kl[slot];
		if ($urandom_range(0, 99) < 5) begin
			kh = 16'($urandom);
			kl = {$urandom, $urandom};
		end
		roll = $urandom_range(0, 99);
		if (roll < 3)
			wall_clock = $urandom;
		else if (roll < 5)
			wall_clock = 32'hFFFF_FFFF - $urandom_range(0, int'(timeout_now) + 50);
		else
			wall_clock = wall_clock + $urandom_range(0, int'(timeout_now) / 4 + 2);
		offer(op, kh, kl, wall_clock);
	endtask

	initial begin : stimulus
		int n;
		int phase;
		int unsigned timeout_plan [PHASES];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_NONE;
		key_high     = '0;
		key_low      = '0;
		now_seconds  = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		calm         = 1'b0;
		hold_request = 1'b0;
		timeout_now  = TIMEOUT_RESET;
		wall_clock   = '0;
		timeout_plan = '{65535, 1, 0, 300, 1800, 0};
		timeout_plan[PHASES-1] = $urandom_range(1, 65535);
		for (n = 0; n < POOL_SIZE; n++) begin
			pool_kh[n] = 16'($urandom);
			pool_kl[n] = {$urandom, $urandom};
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookups and a no-op on the empty table
		offer(OP_VALIDATE, '0, '0, 32'd0);
		offer(OP_REMOVE, '0, '0, 32'd0);
		offer(OP_NONE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		// duplicate key: remove acts on the first copy
		offer(OP_CREATE, '0, '0, 32'd100);
		offer(OP_CREATE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd100);
		offer(OP_CREATE, '0, '0, 32'd200);
		offer(OP_VALIDATE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd300);
		offer(OP_REMOVE, '0, '0, 32'd300);
		// everything has expired by now
		offer(OP_VALIDATE, '0, '0, 32'd5000);
		// fill past capacity to force an eviction
		for (n = 0; n < 11; n++)
			offer(OP_CREATE, 16'(n), {32'hA5A5_0000 | n, 32'h5A5A_FFFF}, 32'd6000);
		// mass expiry, then expiry clamped at the top of the time range
		offer(OP_CREATE, 16'h1234, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFF0);
		offer(OP_VALIDATE, 16'h1234, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF);
		offer(OP_NONE, '0, '0, 32'hFFFF_FFFF);
		drain();

		// zero lifetime: live at the same second, gone one second later
		load_timeout(16'd0);
		offer(OP_CREATE, 16'h00FF, 64'hFF00_FF00_FF00_FF00, 32'd50);
		offer(OP_VALIDATE, 16'h00FF, 64'hFF00_FF00_FF00_FF00, 32'd50);
		offer(OP_VALIDATE, 16'h00FF, 64'hFF00_FF00_FF00_FF00, 32'd51);
		drain();

		// random phases, one timeout setting each; the last runs without idling
		for (phase = 0; phase < PHASES; phase++) begin
			load_timeout(16'(timeout_plan[phase]));
			if (phase == 0)
				hold_request = 1'b1;
			if (phase == PHASES - 1)
				calm = 1'b1;
			for (n = 0; n < RANDOM_PER_PHASE; n++)
				offer_random();
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### files.f
src/askt_pkg.sv
src/askt_cell.sv
src/aging_session_key_table.sv
tb/session_table_monitor.sv
tb/tb_aging_session_key_table.sv
